// ===== sv/rpn_pkg.sv =====
// Package for the RPN evaluator: word types, character codes and status codes.
package rpn_pkg;

	// Data word and status field types.
	localparam int WORD_W = 32;
	localparam int STATUS_W = 3;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [7:0] char_t;

	// Default stack depth in words.
	localparam int STACK_DEPTH_DEF = 128;

	// Character codes that the evaluator recognises.
	localparam char_t CH_EQ = 8'h3D;
	localparam char_t CH_ZERO = 8'h30;
	localparam char_t CH_NINE = 8'h39;
	localparam char_t CH_ADD = 8'h2B;
	localparam char_t CH_SUB = 8'h2D;
	localparam char_t CH_MUL = 8'h2A;
	localparam char_t CH_DIV = 8'h2F;

	// Result status codes.
	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_OVERFLOW = 3'd1;
	localparam status_t ST_UNDERFLOW = 3'd2;
	localparam status_t ST_LEFTOVER = 3'd3;
	localparam status_t ST_BADCHAR = 3'd4;
	localparam status_t ST_DIVZERO = 3'd5;

endpackage

// ===== sv/rpn_expression_evaluator.sv =====
// Top level of the RPN evaluator: stack memory, sequencer and iterative divider.

// One character is transferred per item. The operand stack is a synchronous
// memory of STACK_DEPTH 32-bit words with one write port and one read port;
// an operator reads its two operands one after the other through the
// memory's single read port and then writes its result back. A digit is
// pushed as it is transferred; '/' runs the divider between the reads and
// the write-back (the divider produces one quotient bit per cycle) unless
// the divisor is zero, and '=' reads the word back when exactly one word is
// on the stack. A result or an error status waits in the emit state while an
// earlier result is still held, and is then registered into the output.
// A character whose result is pending is not blocked by the previous result
// until it needs the output register itself. Errors clear the stack, and
// characters are then discarded up to and including the next '='; the stack
// memory needs no clearing pass, since only entries below the stack pointer
// are ever read.
module rpn_expression_evaluator #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  rpn_pkg::char_t  char_code,
	output logic            result_valid,
	input  logic            result_stall,
	output rpn_pkg::word_t  value,
	output rpn_pkg::status_t status
);
	import rpn_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(WORD_W);

	// Sequencer state codes.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1 = 3'd1;
	localparam logic [2:0] S_RD2 = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_WB = 3'd4;
	localparam logic [2:0] S_RDEQ = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [SP_W-1:0] sp_q;
	logic err_q;
	char_t op_q;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q;
	logic res_valid_q;
	word_t value_q;
	status_t status_q;
	word_t pend_value_q;
	status_t pend_status_q;

	word_t stack_mem [STACK_DEPTH];
	word_t rd_data_q;
	word_t r_q;
	word_t res_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W-1:0] rem_q;

	logic accept;
	logic is_digit;
	logic is_op;
	logic out_free;
	logic [SP_W-1:0] sp_m1;
	logic [SP_W-1:0] sp_m2;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	word_t wr_data;
	word_t l_op;
	logic [WORD_W-1:0] mag_l;
	logic [WORD_W-1:0] mag_r;
	logic [WORD_W:0] rem_sh;
	logic [WORD_W:0] trial;
	word_t quo_signed;

	// Decode of the incoming character and handshake terms.
	assign char_stall = (state_q != S_IDLE);
	assign accept = char_valid && !char_stall;
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_op = (char_code == CH_ADD) || (char_code == CH_SUB) ||
		(char_code == CH_MUL) || (char_code == CH_DIV);
	assign out_free = !res_valid_q || !result_stall;
	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);

	// Memory port control: the operand reads are sequenced, and the only
	// writes are a push on transfer or a write-back after the reads.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = sp_m1[ADDR_W-1:0];
		wr_en = 1'b0;
		wr_addr = sp_q[ADDR_W-1:0];
		wr_data = {24'd0, char_code - CH_ZERO};
		case (state_q)
			S_IDLE: begin
				if (accept && !err_q) begin
					if (is_digit && (sp_q < SP_W'(STACK_DEPTH))) begin
						wr_en = 1'b1;
					end else if (char_code == CH_EQ && sp_q == SP_W'(1)) begin
						rd_en = 1'b1;
						rd_addr = '0;
					end else if (is_op && sp_q >= SP_W'(2)) begin
						rd_en = 1'b1;
					end
				end
			end
			S_RD1: begin
				rd_en = 1'b1;
				rd_addr = sp_m2[ADDR_W-1:0];
			end
			S_WB: begin
				wr_en = 1'b1;
				wr_addr = sp_m2[ADDR_W-1:0];
				wr_data = (op_q == CH_DIV) ? quo_signed : res_q;
			end
			default: begin
			end
		endcase
	end

	// Stack memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// Operand magnitudes and one restoring division step.
	assign l_op = rd_data_q;
	assign mag_l = l_op[WORD_W-1] ? (WORD_W'(0) - l_op) : l_op;
	assign mag_r = r_q[WORD_W-1] ? (WORD_W'(0) - r_q) : r_q;
	assign rem_sh = {rem_q, dvd_q[WORD_W-1]};
	assign trial = rem_sh - {1'b0, dvs_q};
	assign quo_signed = neg_q ? (WORD_W'(0) - dvd_q) : dvd_q;

	// Datapath registers: operands, arithmetic result and divider.
	always_ff @(posedge clk) begin
		case (state_q)
			S_RD1: begin
				r_q <= rd_data_q;
			end
			S_RD2: begin
				case (op_q)
					CH_ADD: res_q <= l_op + r_q;
					CH_SUB: res_q <= l_op - r_q;
					CH_MUL: res_q <= l_op * r_q;
					default: res_q <= '0;
				endcase
				dvd_q <= mag_l;
				dvs_q <= mag_r;
				rem_q <= '0;
				neg_q <= l_op[WORD_W-1] ^ r_q[WORD_W-1];
			end
			S_DIV: begin
				if (!trial[WORD_W]) begin
					rem_q <= trial[WORD_W-1:0];
				end else begin
					rem_q <= rem_sh[WORD_W-1:0];
				end
				dvd_q <= {dvd_q[WORD_W-2:0], ~trial[WORD_W]};
			end
			default: begin
			end
		endcase
	end

	// The result register fills from the sequencer and empties once its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Sequencer, stack pointer, error latch and result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			err_q <= 1'b0;
			op_q <= '0;
			cnt_q <= '0;
			value_q <= '0;
			status_q <= ST_OK;
			pend_value_q <= '0;
			pend_status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= char_code;
						pend_value_q <= '0;
						if (err_q) begin
							if (char_code == CH_EQ) begin
								err_q <= 1'b0;
								sp_q <= '0;
							end
						end else if (is_digit) begin
							if (sp_q < SP_W'(STACK_DEPTH)) begin
								sp_q <= sp_q + SP_W'(1);
							end else begin
								sp_q <= '0;
								err_q <= 1'b1;
								pend_status_q <= ST_OVERFLOW;
								state_q <= S_EMIT;
							end
						end else if (char_code == CH_EQ) begin
							sp_q <= '0;
							if (sp_q == '0) begin
								pend_status_q <= ST_UNDERFLOW;
								state_q <= S_EMIT;
							end else if (sp_q > SP_W'(1)) begin
								pend_status_q <= ST_LEFTOVER;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_RDEQ;
							end
						end else if (!is_op) begin
							sp_q <= '0;
							err_q <= 1'b1;
							pend_status_q <= ST_BADCHAR;
							state_q <= S_EMIT;
						end else if (sp_q < SP_W'(2)) begin
							sp_q <= '0;
							err_q <= 1'b1;
							pend_status_q <= ST_UNDERFLOW;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_RD1;
						end
					end
				end
				S_RD1: begin
					state_q <= S_RD2;
				end
				S_RD2: begin
					cnt_q <= '0;
					if (op_q != CH_DIV) begin
						state_q <= S_WB;
					end else if (r_q == '0) begin
						sp_q <= '0;
						err_q <= 1'b1;
						pend_status_q <= ST_DIVZERO;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(WORD_W - 1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					sp_q <= sp_m1;
					state_q <= S_IDLE;
				end
				S_RDEQ: begin
					pend_value_q <= rd_data_q;
					pend_status_q <= ST_OK;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						value_q <= pend_value_q;
						status_q <= pend_status_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign value = value_q;
	assign status = status_q;

	// The stack pointer never passes the depth of the memory.
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	// The divider only runs with a nonzero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (dvs_q != '0))
		else $error("divider running with zero divisor");

	// A write-back pops exactly one word.
	a_wb_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |=> (sp_q == $past(sp_m1)))
		else $error("write-back did not pop one word");

	// An '=' while an error is latched clears the latch and the stack.
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q && char_code == CH_EQ) |=> (!err_q && sp_q == '0))
		else $error("error latch not cleared by '='");

endmodule
